[rtl/page_crc16_ccitt_top_defines.svh]
// Assertion macros shared by the page CRC checker.
`ifndef PAGE_CRC16_CCITT_TOP_DEFINES_SVH
`define PAGE_CRC16_CCITT_TOP_DEFINES_SVH

// Property checked only while out of reset
`define PCRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define PCRC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pcrc_pkg.sv]
// Package with types, constants and the CRC byte update of the page checksum.
`timescale 1ns / 1ps
`default_nettype none

package pcrc_pkg;

	localparam logic [15:0] CRC_SEED      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'h8408;
	localparam logic [8:0]  MAX_PAGE      = 9'd256;
	localparam logic [8:0]  PAGE_SIZE_RST = 9'd64;

	// One input transaction as it sits in the input register
	typedef struct packed {
		logic        start;
		logic [15:0] seed_crc;   // CRC after seed and both address bytes
		logic [7:0]  data;
	} pcrc_item_t;

	// Result produced by the CRC engine for the item being processed
	typedef struct packed {
		logic        valid;
		logic [15:0] crc;
	} pcrc_result_t;

	// Reflected CRC-16 update with one byte, LSB first
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/pcrc_engine.sv]
// Running CRC state of the open page and completion detection.
`timescale 1ns / 1ps
`default_nettype none

module pcrc_engine
	import pcrc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         advance,     // item in the input register is consumed
	input  pcrc_item_t        item,
	input  wire logic [8:0]   page_size,
	output pcrc_result_t      result
);

	logic [15:0] crc_q;
	logic [8:0]  count_q;
	logic        open_q;

	logic [15:0] fold_in;
	logic [15:0] crc_nx;
	logic [8:0]  count_nx;
	logic [8:0]  eff_size;
	logic        take;
	logic        done;

	// Zero counts as one, anything above the maximum saturates
	always_comb begin
		if (page_size == '0) begin
			eff_size = 9'd1;
		end else if (page_size > MAX_PAGE) begin
			eff_size = MAX_PAGE;
		end else begin
			eff_size = page_size;
		end
	end

	// Fold the byte into either the fresh address CRC or the running CRC
	always_comb begin
		fold_in  = item.start ? item.seed_crc : crc_q;
		crc_nx   = crc_fold(fold_in, item.data);
		count_nx = item.start ? 9'd1 : count_q + 9'd1;
		take     = item.start || open_q;
		done     = take && (count_nx >= eff_size);
	end

	assign result.valid = done;
	assign result.crc   = crc_nx;

	// Page state; a byte with no page open leaves it untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_SEED;
			count_q <= '0;
			open_q  <= 1'b0;
		end else if (advance && take) begin
			crc_q   <= crc_nx;
			count_q <= count_nx;
			open_q  <= !done;
		end
	end

endmodule

`default_nettype wire

[rtl/page_crc16_ccitt_top.sv]
// Top level of the firmware page CRC-16 CCITT checksum block.
`timescale 1ns / 1ps
`default_nettype none

// Page checksum, reflected CRC-16 CCITT (poly 0x8408, seed 0xFFFF, no final XOR).
// A transaction with tuser set opens a page: the CRC is reseeded, the page address is
// folded in low byte first, then the data byte. Later bytes extend the page until
// page_size bytes have been folded, then the CRC is sent on the master side. Bytes
// arriving with no page open are dropped; a new start abandons an open page.
// Throughput is one byte per clock while the result side is ready; m_axis_tvalid rises
// at the clock edge after the one that takes the last byte, unless an earlier result is
// still stalled, and a stalled result holds off the input once the input register is
// full. The rate is set by the combinational byte fold that feeds the running CRC
// register. page_size (0 acts as 1, above 256 acts as 256) is written via cfg_wen.
module page_crc16_ccitt_top
	import pcrc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration
	input  wire logic         cfg_wen,
	input  wire logic [8:0]   cfg_wdata,      // page_size
	// input stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [23:0]  s_axis_tdata,   // [15:0] page_address, [23:16] data_byte
	input  wire logic         s_axis_tuser,   // [0] page_start
	// result stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [15:0]       m_axis_tdata    // [15:0] page checksum
);

	logic [8:0]    page_size_q;
	logic          valid_s1;
	pcrc_item_t    item_s1;
	logic          out_valid_q;
	logic [15:0]   out_crc_q;
	logic          advance;
	logic          s_accept;
	pcrc_result_t  result;
	logic [15:0]   addr_crc;

	// Page size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= PAGE_SIZE_RST;
		end else if (cfg_wen) begin
			page_size_q <= cfg_wdata;
		end
	end

	// Handshake: the input register moves on whenever the output slot is free or draining
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// Address CRC is known at entry, so fold it before the input register
	assign addr_crc = crc_fold(crc_fold(CRC_SEED, s_axis_tdata[7:0]), s_axis_tdata[15:8]);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.start    <= s_axis_tuser;
			item_s1.seed_crc <= addr_crc;
			item_s1.data     <= s_axis_tdata[23:16];
		end
	end

	pcrc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.page_size (page_size_q),
		.result    (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			out_crc_q <= result.crc;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_crc_q;

endmodule

`default_nettype wire

[rtl/pcrc_checker.sv]
// Port-level checker for the page CRC block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "page_crc16_ccitt_top_defines.svh"

module pcrc_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [15:0]  m_axis_tdata
);

	// No result is offered while in reset
	`PCRC_ASSERT_ALWAYS(a_no_valid_in_reset, !arst_n |-> !m_axis_tvalid, "result valid during reset")

	// A stalled result stays offered
	`PCRC_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

	// A stalled result keeps its value
	`PCRC_ASSERT(a_hold_data, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")

	// A new result is preceded by an input transaction that passed the input and output registers
	`PCRC_ASSERT(a_result_latency, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2), "result without input transaction")

endmodule

bind page_crc16_ccitt_top pcrc_checker u_pcrc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/sv/page_crc_checker.sv]
`timescale 1ns / 1ps
// Checker for the page CRC block: tracks pages on the input stream, predicts each CRC, compares.
module page_crc_checker
	import pcrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [8:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,    // [15:0] page_address, [23:16] data_byte
	input  logic        s_axis_tuser,    // [0] page_start
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,    // [15:0] page checksum
	output int          mismatch_count,
	output int          pending_crcs
);

	localparam int PRINT_LIMIT = 200;

	// page model state
	logic [8:0]  page_size_reg = PAGE_SIZE_RST;
	logic [15:0] running_crc   = CRC_SEED;
	logic [8:0]  bytes_in_page = '0;
	logic        page_is_open  = 1'b0;
	logic [15:0] expected_crcs[$];
	int          fails         = 0;
	int          queued        = 0;

	assign mismatch_count = fails;
	assign pending_crcs   = queued;

	// reflected CRC-16 update, one data bit at a time, LSB first
	function automatic logic [15:0] fold_crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = {1'b0, c[15:1]};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// zero acts as one, anything past the maximum saturates
	function automatic logic [8:0] page_limit(input logic [8:0] sz);
		if (sz == 9'd0) begin
			return 9'd1;
		end
		if (sz > MAX_PAGE) begin
			return MAX_PAGE;
		end
		return sz;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fails < PRINT_LIMIT) begin
			$display("[%0t] page checksum mismatch: %s", $time, msg);
		end
		fails++;
	endtask

	// advance the page model by one accepted byte
	task automatic fold_page_byte(input logic [15:0] addr, input logic [7:0] b, input logic start);
		if (start) begin
			running_crc   = fold_crc_byte(CRC_SEED, addr[7:0]);
			running_crc   = fold_crc_byte(running_crc, addr[15:8]);
			running_crc   = fold_crc_byte(running_crc, b);
			bytes_in_page = 9'd1;
			page_is_open  = 1'b1;
		end else if (page_is_open) begin
			running_crc   = fold_crc_byte(running_crc, b);
			bytes_in_page = bytes_in_page + 9'd1;
		end else begin
			// stray byte, no page open
			return;
		end
		if (bytes_in_page >= page_limit(page_size_reg)) begin
			page_is_open = 1'b0;
			expected_crcs.push_back(running_crc);
		end
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			page_size_reg = PAGE_SIZE_RST;
			running_crc   = CRC_SEED;
			bytes_in_page = '0;
			page_is_open  = 1'b0;
			expected_crcs.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_crcs.size() == 0) begin
					report_mismatch($sformatf("unexpected result %04h", m_axis_tdata));
				end else begin
					want = expected_crcs.pop_front();
					if (m_axis_tdata !== want) begin
						report_mismatch($sformatf("got %04h, expected %04h", m_axis_tdata, want));
					end
				end
			end
			if (cfg_wen) begin
				page_size_reg = cfg_wdata;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				fold_page_byte(s_axis_tdata[15:0], s_axis_tdata[23:16], s_axis_tuser);
			end
		end
		queued = expected_crcs.size();
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the page CRC block: stimulus, flow control, watchdog and verdict.
module tb_top;
	import pcrc_pkg::*;

	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS   = 90;
	localparam int NUM_PHASES    = 10;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b1;
	logic        cfg_wen       = 1'b0;
	logic [8:0]  cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;   // [15:0] page_address, [23:16] data_byte
	logic        s_axis_tuser  = 1'b0; // [0] page_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [15:0] page checksum

	int mismatch_count;
	int pending_crcs;
	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;
	int bytes_sent     = 0;
	int page_len       = int'(PAGE_SIZE_RST);

	always #5 clk = ~clk;

	page_crc16_ccitt_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	page_crc_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.mismatch_count (mismatch_count),
		.pending_crcs   (pending_crcs)
	);

	// result side back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// watchdog: cycles with no transaction on either stream
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one byte transaction, with random gaps ahead of it
	task automatic send_byte(input logic [15:0] addr, input logic [7:0] b, input logic start);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, addr};
		s_axis_tuser  <= start;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	task automatic send_random_byte(input logic start);
		send_byte(16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 8'hFF)), start);
	endtask

	// wait for all pages to come out, then let the pipeline empty
	task automatic drain_and_settle();
		s_axis_tvalid <= 1'b0;
		do begin
			@(negedge clk);
		end while (pending_crcs != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_page_size(input logic [8:0] sz);
		drain_and_settle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= sz;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		page_len  = (sz == 9'd0) ? 1 : ((sz > MAX_PAGE) ? int'(MAX_PAGE) : int'(sz));
	endtask

	// random pages: mostly complete, some cut short by a new start, some stray bytes
	task automatic run_page_phase(input logic [8:0] sz, input int mode);
		int first;
		int r;
		int n;
		write_page_size(sz);
		case (mode)
			0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_gap_pct = 71; recv_stall_pct = 0;  end
			2: begin send_gap_pct = 0;  recv_stall_pct = 71; end
			default: begin send_gap_pct = 29; recv_stall_pct = 29; end
		endcase
		first = bytes_sent;
		while (bytes_sent - first < PHASE_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_random_byte(1'b1);
				repeat (page_len - 1) send_random_byte(1'b0);
			end else if (r < 88) begin
				n = (page_len > 1) ? $urandom_range(0, page_len - 2) : 0;
				send_random_byte(1'b1);
				repeat (n) send_random_byte(1'b0);
			end else begin
				repeat ($urandom_range(1, 3)) send_random_byte(1'b0);
			end
		end
	endtask

	initial begin
		logic [8:0] sz;
		// assert reset at time zero so the asynchronous reset sees a falling edge
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: open a page at the reset size, then shrink it under the open page
		send_byte(16'hFFFF, 8'hFF, 1'b1);
		send_byte(16'h1234, 8'h00, 1'b0);
		write_page_size(9'd2);
		send_byte(16'h0000, 8'hA5, 1'b0);
		// stray byte with no page open
		send_byte(16'hBEEF, 8'h5A, 1'b0);
		// size zero behaves as one
		write_page_size(9'd0);
		send_byte(16'h0000, 8'h00, 1'b1);
		send_byte(16'hFFFF, 8'hFF, 1'b1);
		send_byte(16'h8001, 8'h80, 1'b1);
		// oversize saturates; leave a page open and shrink it to three
		write_page_size(9'd511);
		send_byte(16'h00FF, 8'h01, 1'b1);
		write_page_size(9'd3);
		send_byte(16'hAAAA, 8'h55, 1'b0);
		// restart abandons the open page
		send_byte(16'h5555, 8'hAA, 1'b1);
		send_byte(16'h0F0F, 8'h01, 1'b0);
		send_byte(16'hF0F0, 8'hFE, 1'b0);
		write_page_size(9'd1);
		send_byte(16'h7FFF, 8'h7F, 1'b1);

		// random phases over page sizes and flow-control modes
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: sz = 9'd1;
				3: sz = 9'd256;
				6: sz = 9'd511;
				8: sz = 9'd0;
				default: sz = 9'($urandom_range(2, 20));
			endcase
			run_page_phase(sz, ph % 4);
		end

		drain_and_settle();
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
